@@ rtl/lwmr_pkg.sv @@
// Lee wave maze router: shared types and constants.
// No dependencies.
package lwmr_pkg;
    localparam int REACH = 8;
    localparam int CELLS = REACH * REACH;
    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_WALL   = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SOLVE = 1'b1;
    localparam logic CFG_ROWS  = 1'b0;
    localparam logic CFG_COLS  = 1'b1;

    typedef struct packed {
        logic       clear;   // start of solve: reset wave labels
        logic       seed;    // mark start cell as labeled 0
        logic       expand;  // one wave step
        logic [5:0] wave;    // wave number being assigned
    } cell_ctl_t;
endpackage

@@ rtl/lee_wave_maze_router_unit.sv @@
// Lee wave maze router top level: cell array, wave sequencer, backtrace, output.
// Depends on lwmr_pkg and lwmr_cell.
//
// Usage: s_ channel takes items. cmd load writes one cell.
// cmd solve floods the wave across an 8x8 array of cells, one wave front per
// cycle (all cells of a front labeled at once), stopping when the finish
// cell borders the front or the front empties. A backtrace then walks from
// the finish to the start one cell per cycle, and the path goes out on the
// m_ channel start first, the final one with m_last. No path gives one item with found 0.
// Configuration: cfg_ channel, index 0 rows, 1 columns; to be written when idle, which the block does not enforce.
// Reset clears the maze to all free, start and finish to cell 0, sizes 8.
// A stalled receiver holds the output register; the sequencer waits.
module lee_wave_maze_router_unit
    import lwmr_pkg::*;
#(
    parameter int GRID_SIDE = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic [2:0] s_cell_row,
    input  logic [2:0] s_cell_column,
    input  logic [1:0] s_cell_kind,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_path_row,
    output logic [2:0] m_path_column,
    output logic [5:0] m_step_number,
    output logic       m_found,
    output logic       m_last
);
    localparam int LIM = (GRID_SIDE < REACH) ? GRID_SIDE : REACH;
    localparam logic [3:0] LIM4 = 4'(LIM);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEED, ST_WAVE, ST_TRACE, ST_EMIT, ST_NONE
    } state_t;

    state_t     state_reg;
    logic [3:0] rows_reg, cols_reg;
    logic [5:0] start_reg, finish_reg;
    logic [5:0] wave_reg;
    logic [5:0] pos_reg;
    logic [5:0] stack_mem [CELLS];
    logic [6:0] len_reg;
    logic [6:0] idx_reg;
    logic [5:0] rd_reg;

    logic       out_valid_reg;
    logic [2:0] out_row_reg, out_col_reg;
    logic [5:0] out_step_reg;
    logic       out_found_reg, out_last_reg;

    cell_ctl_t  ctl;
    logic [CELLS-1:0] seen_v, front_v;
    logic [5:0] dist_v [CELLS];
    logic [CELLS-1:0] use_v;

    logic [3:0] lr, lc;
    assign lr = (rows_reg > LIM4) ? LIM4 : rows_reg;
    assign lc = (cols_reg > LIM4) ? LIM4 : cols_reg;

    logic load_fire;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign load_fire = s_valid && s_ready && s_cmd == CMD_LOAD
                       && 32'(s_cell_row) < GRID_SIDE && 32'(s_cell_column) < GRID_SIDE;

    // cell array
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        localparam int R = g / REACH;
        localparam int C = g % REACH;
        logic [3:0] nf;
        logic ue;
        assign ue = (4'(R) < lr) && (4'(C) < lc);
        assign use_v[g] = ue;
        assign nf[0] = (R > 0)         ? front_v[(R > 0 ? g - REACH : g)] : 1'b0;
        assign nf[1] = (C < REACH - 1) ? front_v[(C < REACH - 1 ? g + 1 : g)] : 1'b0;
        assign nf[2] = (R < REACH - 1) ? front_v[(R < REACH - 1 ? g + REACH : g)] : 1'b0;
        assign nf[3] = (C > 0)         ? front_v[(C > 0 ? g - 1 : g)] : 1'b0;
        lwmr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load_en  (load_fire && {s_cell_row, s_cell_column} == 6'(g)),
            .load_kind(s_cell_kind),
            .in_use   (ue),
            .is_start (start_reg == 6'(g)),
            .ctl      (ctl),
            .nbr_front(nf),
            .seen     (seen_v[g]),
            .label    (dist_v[g]),
            .front    (front_v[g])
        );
    end

    // neighbors of a position, up right down left
    function automatic logic [3:0] nbr_ok(input logic [5:0] p, input logic [3:0] r,
                                          input logic [3:0] c);
        logic [3:0] pr, pc;
        begin
            pr = {1'b0, p[5:3]};
            pc = {1'b0, p[2:0]};
            nbr_ok[0] = pr != 4'd0 && (pr - 4'd1) < r && pc < c;
            nbr_ok[1] = pr < r && (pc + 4'd1) < c;
            nbr_ok[2] = (pr + 4'd1) < r && pc < c;
            nbr_ok[3] = pc != 4'd0 && pr < r && (pc - 4'd1) < c;
        end
    endfunction

    function automatic logic [5:0] nbr_pos(input logic [5:0] p, input logic [1:0] d);
        case (d)
            2'd0:    nbr_pos = p - 6'd8;
            2'd1:    nbr_pos = p + 6'd1;
            2'd2:    nbr_pos = p + 6'd8;
            default: nbr_pos = p - 6'd1;
        endcase
    endfunction

    // finish adjacent to the current front; a finish outside the grid in use is never reached
    logic [3:0] fok;
    logic       fin_hit;
    assign fok = nbr_ok(finish_reg, lr, lc);
    always_comb begin
        fin_hit = 1'b0;
        for (int d = 0; d < 4; d++) begin
            if (use_v[finish_reg] && fok[d] && front_v[nbr_pos(finish_reg, 2'(d))]) begin
                fin_hit = 1'b1;
            end
        end
    end

    // backtrace choice
    logic [3:0] pok;
    logic [5:0] tr_next;
    logic       tr_ok;
    assign pok = nbr_ok(pos_reg, lr, lc);
    always_comb begin
        tr_next = '0;
        tr_ok   = 1'b0;
        for (int d = 3; d >= 0; d--) begin
            if (pok[d] && seen_v[nbr_pos(pos_reg, 2'(d))]
                && dist_v[nbr_pos(pos_reg, 2'(d))] == wave_reg - 6'd1) begin
                tr_next = nbr_pos(pos_reg, 2'(d));
                tr_ok   = 1'b1;
            end
        end
    end

    logic start_in;
    assign start_in = use_v[start_reg];

    always_comb begin
        ctl = '0;
        ctl.wave   = wave_reg;
        ctl.clear  = (state_reg == ST_IDLE) && s_valid && s_cmd == CMD_SOLVE;
        ctl.seed   = (state_reg == ST_SEED);
        ctl.expand = (state_reg == ST_WAVE) && !fin_hit && |front_v;
    end

    logic out_free;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_TRACE) begin
            stack_mem[len_reg[5:0]] <= pos_reg;
        end
        rd_reg <= stack_mem[idx_reg[5:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rows_reg      <= 4'd8;
            cols_reg      <= 4'd8;
            start_reg     <= '0;
            finish_reg    <= '0;
            out_valid_reg <= 1'b0;
            wave_reg      <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_ROWS) rows_reg <= cfg_data;
                else                       cols_reg <= cfg_data;
            end
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (load_fire && s_cell_kind == KIND_START)
                        start_reg <= {s_cell_row, s_cell_column};
                    if (load_fire && s_cell_kind == KIND_FINISH)
                        finish_reg <= {s_cell_row, s_cell_column};
                    if (s_valid && s_cmd == CMD_SOLVE) begin
                        state_reg <= ST_SEED;
                    end
                end
                ST_SEED: begin
                    wave_reg <= 6'd1;
                    len_reg  <= '0;
                    pos_reg  <= finish_reg;
                    if (!start_in) state_reg <= ST_NONE;
                    else if (start_reg == finish_reg) begin
                        wave_reg  <= 6'd0;
                        state_reg <= ST_TRACE;
                    end else state_reg <= ST_WAVE;
                end
                ST_WAVE: begin
                    if (fin_hit) state_reg <= ST_TRACE;
                    else if (!(|front_v)) state_reg <= ST_NONE;
                    else wave_reg <= wave_reg + 6'd1;
                end
                ST_TRACE: begin
                    len_reg <= len_reg + 7'd1;
                    if (wave_reg == 6'd0 || !tr_ok || len_reg == 7'(CELLS - 1)) begin
                        idx_reg   <= len_reg;
                        state_reg <= ST_EMIT;
                    end else begin
                        pos_reg  <= tr_next;
                        wave_reg <= wave_reg - 6'd1;
                    end
                end
                ST_EMIT: begin
                    // rd_reg is a registered read at idx_reg; wave_reg used as phase flag
                    if (out_free && wave_reg == 6'd63) begin
                        out_valid_reg <= 1'b1;
                        out_row_reg   <= rd_reg[5:3];
                        out_col_reg   <= rd_reg[2:0];
                        out_step_reg  <= 6'(len_reg - 7'd1 - idx_reg);
                        out_found_reg <= 1'b1;
                        out_last_reg  <= idx_reg == 7'd0;
                        wave_reg      <= 6'd0;
                        if (idx_reg == 7'd0) state_reg <= ST_IDLE;
                        else idx_reg <= idx_reg - 7'd1;
                    end else if (wave_reg != 6'd63) begin
                        wave_reg <= 6'd63;
                    end
                end
                ST_NONE: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_row_reg   <= '0;
                        out_col_reg   <= '0;
                        out_step_reg  <= '0;
                        out_found_reg <= 1'b0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_path_row    = out_row_reg;
    assign m_path_column = out_col_reg;
    assign m_step_number = out_step_reg;
    assign m_found       = out_found_reg;
    assign m_last        = out_last_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_step_number))
        else $error("output item changed while stalled");
    a_nf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_last)
        else $error("not-found item without last");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WAVE |-> !s_ready)
        else $error("input taken during wave");
endmodule

@@ rtl/lwmr_cell.sv @@
// Lee wave maze router: one grid cell holding its kind and wave label.
// Depends on lwmr_pkg.
module lwmr_cell
    import lwmr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load_en,
    input  logic [1:0] load_kind,
    input  logic       in_use,
    input  logic       is_start,
    input  cell_ctl_t  ctl,
    input  logic [3:0] nbr_front,
    output logic       seen,
    output logic [5:0] label,
    output logic       front
);
    logic [1:0] kind_reg;
    logic       seen_reg;
    logic [5:0] dist_reg;
    logic       front_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_FREE;
            seen_reg  <= 1'b0;
            front_reg <= 1'b0;
            dist_reg  <= '0;
        end else begin
            if (load_en) begin
                kind_reg <= load_kind;
            end
            if (ctl.clear) begin
                seen_reg  <= 1'b0;
                front_reg <= 1'b0;
                dist_reg  <= '0;
            end else if (ctl.seed) begin
                seen_reg  <= is_start;
                front_reg <= is_start;
            end else if (ctl.expand) begin
                front_reg <= 1'b0;
                if (!seen_reg && in_use && kind_reg == KIND_FREE && |nbr_front) begin
                    seen_reg  <= 1'b1;
                    front_reg <= 1'b1;
                    dist_reg  <= ctl.wave;
                end
            end
        end
    end

    assign seen  = seen_reg;
    assign label = dist_reg;
    assign front = front_reg;
endmodule

@@ sim/tb_top.sv @@
// Testbench for lee_wave_maze_router_unit: loads mazes, solves them and checks each path item.
// Depends on lwmr_pkg and the router RTL; holds its own breadth-first path predictor.
`timescale 1ns / 1ps

module tb_top;
    import lwmr_pkg::*;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic [5:0] step;
        logic       found;
        logic       last;
    } path_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_cmd = 1'b0;
    logic [2:0] s_cell_row = '0;
    logic [2:0] s_cell_column = '0;
    logic [1:0] s_cell_kind = '0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [3:0] cfg_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_path_row;
    logic [2:0] m_path_column;
    logic [5:0] m_step_number;
    logic       m_found;
    logic       m_last;

    lee_wave_maze_router_unit DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [1:0] maze_kind [CELLS];
    logic [5:0] start_cell, finish_cell;
    logic [3:0] rows_reg, cols_reg;
    path_item_t expected_path [$];
    int errors = 0;
    int solves = 0;
    int path_items = 0;
    int idle_pct = 19;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;

    function automatic int clip(logic [3:0] v);
        return (v > 8) ? 8 : int'(v);
    endfunction

    function automatic int step_to(int p, int d, int lr, int lc);
        int r, c;
        r = p / 8 + ((d == 0) ? -1 : (d == 2) ? 1 : 0);
        c = p % 8 + ((d == 3) ? -1 : (d == 1) ? 1 : 0);
        if (r < 0 || c < 0 || r >= lr || c >= lc) return -1;
        return r * 8 + c;
    endfunction

    task automatic predict_path();
        int lr, lc, wave, fdist, n, m, q, len, nxt;
        int s, f;
        bit found;
        bit seen [CELLS];
        int wave_at [CELLS];
        int front [$];
        int nfront [$];
        int path [$];
        path_item_t it;
        lr = clip(rows_reg);
        lc = clip(cols_reg);
        s = int'(start_cell);
        f = int'(finish_cell);
        found = 0;
        wave = 0;
        fdist = 0;
        foreach (seen[i]) begin
            seen[i] = 0;
            wave_at[i] = 0;
        end
        if (s / 8 < lr && s % 8 < lc) begin
            if (s == f) begin
                found = 1;
            end else begin
                seen[s] = 1;
                front = {front, s};
                while (!found && front.size() > 0) begin
                    nfront.delete();
                    wave++;
                    for (int i = 0; i < front.size() && !found; i++) begin
                        for (int d = 0; d < 4; d++) begin
                            q = step_to(front[i], d, lr, lc);
                            if (q < 0) continue;
                            if (q == f) begin
                                fdist = wave;
                                found = 1;
                                break;
                            end
                            if (maze_kind[q] == KIND_FREE && !seen[q]) begin
                                seen[q] = 1;
                                wave_at[q] = wave;
                                nfront = {nfront, q};
                            end
                        end
                    end
                    front = nfront;
                end
            end
        end
        if (!found) begin
            it = '{row: 0, col: 0, step: 0, found: 0, last: 1};
            expected_path = {expected_path, it};
            return;
        end
        path = {path, f};
        for (wave = fdist; wave > 0 && path.size() < CELLS; wave--) begin
            nxt = -1;
            for (int d = 0; d < 4; d++) begin
                q = step_to(path[path.size() - 1], d, lr, lc);
                if (q >= 0 && seen[q] && wave_at[q] == wave - 1) begin
                    nxt = q;
                    break;
                end
            end
            if (nxt < 0) break;
            path = {path, nxt};
        end
        len = path.size();
        for (int i = 0; i < len; i++) begin
            it.row = 3'(path[len - 1 - i] / 8);
            it.col = 3'(path[len - 1 - i] % 8);
            it.step = 6'(i);
            it.found = 1'b1;
            it.last = (i == len - 1);
            expected_path = {expected_path, it};
        end
    endtask

    // valid stays up after an accept until the next item or an idle cycle replaces it
    task automatic send_item(logic cmd, logic [2:0] r, logic [2:0] c, logic [1:0] k);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_cell_row <= r;
        s_cell_column <= c;
        s_cell_kind <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == CMD_LOAD) begin
            maze_kind[{r, c}] = k;
            if (k == KIND_START) start_cell = {r, c};
            if (k == KIND_FINISH) finish_cell = {r, c};
        end else begin
            solves++;
            predict_path();
        end
    endtask

    task automatic load_cell(int r, int c, logic [1:0] k);
        send_item(CMD_LOAD, r[2:0], c[2:0], k);
    endtask

    task automatic solve_maze();
        send_item(CMD_SOLVE, 3'($urandom), 3'($urandom), 2'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_path.size() > 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_ROWS) rows_reg = v;
        else cols_reg = v;
    endtask

    task automatic set_size(logic [3:0] r, logic [3:0] c);
        drain();
        write_reg(CFG_ROWS, r);
        write_reg(CFG_COLS, c);
        cfg_valid <= 1'b0;
    endtask

    task automatic clear_maze();
        for (int i = 0; i < CELLS; i++) load_cell(i / 8, i % 8, KIND_FREE);
    endtask

    task automatic test_directed();
        solve_maze();
        load_cell(0, 0, KIND_START);
        load_cell(7, 7, KIND_FINISH);
        solve_maze();
        solve_maze();
        load_cell(3, 3, KIND_WALL);
        load_cell(7, 6, KIND_WALL);
        load_cell(6, 7, KIND_WALL);
        solve_maze();
        load_cell(7, 6, KIND_FREE);
        load_cell(2, 5, KIND_START);
        load_cell(0, 4, KIND_START);
        solve_maze();
        load_cell(0, 4, KIND_FINISH);
        solve_maze();
        set_size(4'd2, 4'd15);
        solve_maze();
        set_size(4'd0, 4'd8);
        solve_maze();
        set_size(4'd8, 4'd1);
        load_cell(0, 0, KIND_START);
        load_cell(5, 0, KIND_FINISH);
        solve_maze();
        set_size(4'd8, 4'd8);
        clear_maze();
    endtask

    task automatic test_random_mazes();
        int density, nload;
        for (int round = 0; round < 20; round++) begin
            if (round % 5 == 4) set_size(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
            if (round % 5 == 0) set_size(4'd8, 4'd8);
            density = $urandom_range(5, 40);
            nload = $urandom_range(5, 11);
            for (int i = 0; i < nload; i++) begin
                load_cell($urandom_range(7), $urandom_range(7),
                    ($urandom_range(99) < density) ? KIND_WALL : KIND_FREE);
            end
            load_cell($urandom_range(7), $urandom_range(7), KIND_START);
            load_cell($urandom_range(7), $urandom_range(7), KIND_FINISH);
            if ($urandom_range(9) == 0)
                send_item(CMD_LOAD, 3'($urandom), 3'($urandom), 2'($urandom));
            solve_maze();
            if ($urandom_range(2) == 0) solve_maze();
        end
    endtask

    // the stall process releases hold_off after its count
    task automatic test_back_pressure();
        hold_off = 1'b1;
        load_cell(0, 0, KIND_START);
        load_cell(0, 7, KIND_FINISH);
        solve_maze();
        solve_maze();
        load_cell(1, 1, KIND_WALL);
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        load_cell(7, 0, KIND_START);
        load_cell(0, 7, KIND_FINISH);
        for (int i = 0; i < 10; i++) begin
            load_cell($urandom_range(7), $urandom_range(7), KIND_WALL);
            solve_maze();
        end
        idle_pct = 19;
    endtask

    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end

    initial begin
        static int stall = 0;
        wait (hold_off);
        while (stall < 300) begin
            @(posedge aclk);
            stall++;
        end
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        path_item_t want;
        if (aresetn && m_valid && m_ready) begin
            path_items++;
            if (expected_path.size() == 0) begin
                $display("%0t: unexpected item row %0d col %0d step %0d found %0b last %0b",
                    $time, m_path_row, m_path_column, m_step_number, m_found, m_last);
                errors++;
            end else begin
                want = expected_path.pop_front();
                if (want.row !== m_path_row || want.col !== m_path_column
                    || want.step !== m_step_number || want.found !== m_found
                    || want.last !== m_last) begin
                    $display("%0t: mismatch expected r%0d c%0d s%0d f%0b l%0b got r%0d c%0d s%0d f%0b l%0b",
                        $time, want.row, want.col, want.step, want.found, want.last,
                        m_path_row, m_path_column, m_step_number, m_found, m_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("%0t: watchdog timeout, %0d items pending", $time, expected_path.size());
            $display("** lee_wave_maze_router_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        foreach (maze_kind[i]) maze_kind[i] = KIND_FREE;
        start_cell = '0;
        finish_cell = '0;
        rows_reg = 4'd8;
        cols_reg = 4'd8;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_back_pressure();
        test_random_mazes();
        test_no_idle();
        drain();
        $display("Ran %0d solves, checked %0d path items over several grid sizes.",
            solves, path_items);
        if (errors == 0 && expected_path.size() == 0) begin
            $display("** lee_wave_maze_router_unit: PASSED **");
        end else begin
            $display("** lee_wave_maze_router_unit: FAILED **");
        end
        $finish;
    end
endmodule
